FILE: hw/rtl/tcw_pkg.sv
// shared types, constants and helpers of the text console writer
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int MODE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int DATA_W   = 16;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int CIDX_W   = 8;
  localparam int CDATA_W  = 8;
  localparam int COLOUR_W = 4;

  localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]   BLANK_CODE   = 8'd32;
  localparam logic [CDATA_W-1:0]  NIBBLE_MASK  = 8'h0F;
  localparam logic [COLOUR_W-1:0] FG_RESET     = 4'd7;
  localparam logic [COLOUR_W-1:0] BG_RESET     = 4'd0;
  localparam logic [DATA_W-1:0]   RESET_CELL   = {BG_RESET, FG_RESET, BLANK_CODE};

  localparam logic [CIDX_W-1:0] REG_FG_COLOR = 8'd0;
  localparam logic [CIDX_W-1:0] REG_BG_COLOR = 8'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_e;

  function automatic logic [DATA_W-1:0] make_cell(input logic [COLOUR_W-1:0] fg,
                                                  input logic [COLOUR_W-1:0] bg,
                                                  input logic [CHAR_W-1:0]   ch);
    make_cell = {bg, fg, ch};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_in_if.sv
// request channel: mode, character and cell address
`default_nettype none

interface tcw_in_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_address;

  modport source (output valid, output mode, output char_code, output cell_address,
                  input ready);
  modport sink   (input valid, input mode, input char_code, input cell_address,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tcw_out_if.sv
// result channel: cell data and cursor position
`default_nettype none

interface tcw_out_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] cell_data;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_column;

  modport source (output valid, output cell_data, output cursor_row, output cursor_column,
                  input ready);
  modport sink   (input valid, input cell_data, input cursor_row, input cursor_column,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tcw_cfg_if.sv
// register write channel
`default_nettype none

interface tcw_cfg_if
  import tcw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/text_console_writer_unit.sv
// text console writer: screen store, cursor and the sequencer that walks the store
//
// in_i carries one item: put a character (mode 0), clear the screen (mode 1)
// or read one cell (mode 2). each accepted item gives exactly one result on
// out_o: the cell read (0 for other modes or an address past the screen) and
// the cursor row and column after the item. cfg_i writes fg_color (index 0)
// and bg_color (index 1) and is always ready; other indexes are ignored.
// per item, the result is offered on out_o as in_i becomes ready again; the
// work between acceptance and result:
//   put without scroll, newline without scroll, unused mode: straight to the result
//   read: a registered store read
//   clear: one cell written per cycle
//   put or newline that scrolls: the single store port
//   pair moving one cell a cycle and then blanking the bottom row
// in_i is ready only while the sequencer is idle; an item may be accepted
// while the previous result still waits on out_o, and its result is held
// until out_o is free. after reset the store is swept to blank light grey on
// black cells before the first item is taken.
`default_nettype none

module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  tcw_in_if.sink     in_i,
  tcw_out_if.source  out_o,
  tcw_cfg_if.sink    cfg_i
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_LAST = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] BOTTOM_ROW  = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);

  state_e state_q, state_d;

  logic [RW-1:0]       row_q, row_d;
  logic [CW-1:0]       col_q, col_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       walk_q, walk_d;
  logic [AW-1:0]       wdst_q, wdst_d;
  logic                wr_pend_q, wr_pend_d;
  logic [COLOUR_W-1:0] fg_q, fg_d;
  logic [COLOUR_W-1:0] bg_q, bg_d;
  logic [DATA_W-1:0]   res_q, res_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;

  logic [DATA_W-1:0] mem [CELLS];
  logic [DATA_W-1:0] rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;

  logic in_fire;
  logic addr_ok;
  logic out_free;
  logic at_last_row;

  assign in_fire     = in_i.valid && in_i.ready;
  assign addr_ok     = 32'(in_i.cell_address) < 32'(CELLS);
  assign out_free    = !out_valid_q || out_o.ready;
  assign at_last_row = (row_q == ROW_LAST);

  assign in_i.ready          = (state_q == ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = out_valid_q;
  assign out_o.cell_data     = out_data_q;
  assign out_o.cursor_row    = out_row_q;
  assign out_o.cursor_column = out_col_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (walk_q == LAST_CELL) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.mode)
            MODE_PUT: begin
              if ((in_i.char_code == NEWLINE_CODE || col_q == COL_LAST) && at_last_row) begin
                state_d = ST_SCROLL;
              end else begin
                state_d = ST_DONE;
              end
            end
            MODE_CLEAR: state_d = ST_FILL;
            MODE_READ:  state_d = addr_ok ? ST_READ : ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_READ:   state_d = ST_DONE;
      ST_SCROLL: begin
        if (walk_q == SCROLL_LAST) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_FILL;
      ST_FILL: begin
        if (walk_q == LAST_CELL) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_INIT;
    endcase
  end

  // datapath and store control
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    cur_d       = cur_q;
    walk_d      = walk_q;
    wdst_d      = wdst_q;
    wr_pend_d   = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_wa      = walk_q;
    mem_wd      = make_cell(fg_q, bg_q, BLANK_CODE);
    mem_ra      = walk_q + ROW_STEP;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;

    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wd = RESET_CELL;
        walk_d = walk_q + AW'(1);
      end
      ST_IDLE: begin
        mem_ra = AW'(in_i.cell_address);
        if (in_fire) begin
          res_d  = '0;
          walk_d = '0;
          case (in_i.mode)
            MODE_PUT: begin
              if (in_i.char_code != NEWLINE_CODE) begin
                mem_we = 1'b1;
                mem_wa = cur_q;
                mem_wd = make_cell(fg_q, bg_q, in_i.char_code);
              end
              if (in_i.char_code == NEWLINE_CODE || col_q == COL_LAST) begin
                col_d = '0;
                if (at_last_row) begin
                  cur_d = BOTTOM_ROW;
                end else begin
                  row_d = row_q + RW'(1);
                  // start of next row from the cursor's linear index
                  cur_d = cur_q - AW'(col_q) + ROW_STEP;
                end
              end else begin
                col_d = col_q + CW'(1);
                cur_d = cur_q + AW'(1);
              end
            end
            MODE_CLEAR: begin
              row_d = '0;
              col_d = '0;
              cur_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: res_d = rd_q;
      ST_SCROLL: begin
        // read the cell one row below, write the one read in the previous cycle
        wr_pend_d = 1'b1;
        wdst_d    = walk_q;
        walk_d    = walk_q + AW'(1);
        if (wr_pend_q) begin
          mem_we = 1'b1;
          mem_wa = wdst_q;
          mem_wd = rd_q;
        end
      end
      ST_DRAIN: begin
        mem_we = 1'b1;
        mem_wa = wdst_q;
        mem_wd = rd_q;
        walk_d = BOTTOM_ROW;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        walk_d = walk_q + AW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          out_row_d   = ROW_W'(row_q);
          out_col_d   = COL_W'(col_q);
        end
      end
      default: ;
    endcase
  end

  // colour registers
  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FG_COLOR: fg_d = COLOUR_W'(cfg_i.data & NIBBLE_MASK);
        REG_BG_COLOR: bg_d = COLOUR_W'(cfg_i.data & NIBBLE_MASK);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      cur_q       <= '0;
      walk_q      <= '0;
      wr_pend_q   <= 1'b0;
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cur_q       <= cur_d;
      walk_q      <= walk_d;
      wr_pend_q   <= wr_pend_d;
      fg_q        <= fg_d;
      bg_q        <= bg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wdst_q     <= wdst_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
  end

  // screen store: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
    else $error("cursor outside the screen");

  a_cursor_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> 32'(cur_q) == 32'(row_q) * COLUMNS + 32'(col_q))
    else $error("linear cursor index out of step with row and column");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("item accepted with no cycle of work");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished item gave no result");
`endif

endmodule

`default_nettype wire
